@@ design/grsp_pkg.sv @@
// ----------------------------------------------------------------------------
// grsp_pkg: shared types and tables for the GDSII record stream parser
// Record table, parse phases and result layout.
// ----------------------------------------------------------------------------
`default_nettype none
package grsp_pkg;

  localparam int unsigned NameCharsDef = 32;
  localparam logic [5:0]  LastIndex    = 6'h38;
  localparam logic [15:0] XyCode       = 16'h1003;
  localparam logic [7:0]  StringIndex  = 8'h19;
  localparam logic [7:0]  StrnameIndex = 8'h06;
  localparam logic [7:0]  BgnstrIndex  = 8'h05;
  localparam logic [7:0]  EndstrIndex  = 8'h07;

  localparam logic [2:0] CfgName0 = 3'd0;
  localparam logic [2:0] CfgName1 = 3'd1;
  localparam logic [2:0] CfgName2 = 3'd2;
  localparam logic [2:0] CfgName3 = 3'd3;
  localparam logic [2:0] CfgNameLen = 3'd4;

  localparam logic [2:0] KindBits  = 3'd1;
  localparam logic [2:0] KindInt2  = 3'd2;
  localparam logic [2:0] KindInt4  = 3'd3;
  localparam logic [2:0] KindReal8 = 3'd5;
  localparam logic [2:0] KindAscii = 3'd6;

  typedef enum logic [2:0] {
    PH_LEN_HI, PH_LEN_LO, PH_CODE_HI, PH_CODE_LO, PH_PAYLOAD
  } phase_e;

  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  len;
    logic        fixed;
    logic        hidden;
  } rec_entry_t;

  typedef struct packed {
    logic [5:0]  record_index;
    logic [2:0]  data_kind;
    logic [63:0] element_value;
    logic [15:0] element_number;
    logic        is_header;
    logic        is_last;
    logic        length_mismatch;
    logic        illegal_code;
    logic        end_of_stream;
  } result_t;

  function automatic rec_entry_t rec_lookup(input logic [5:0] ndx);
    rec_entry_t e;
    e = '{code: 16'h0000, len: 8'd0, fixed: 1'b0, hidden: 1'b0};
    unique case (ndx)
      6'h00: e = '{16'h0002, 8'd2, 1'b1, 1'b0};
      6'h01: e = '{16'h0102, 8'd24, 1'b1, 1'b0};
      6'h02: e = '{16'h0206, 8'd0, 1'b0, 1'b0};
      6'h03: e = '{16'h0305, 8'd16, 1'b1, 1'b0};
      6'h04: e = '{16'h0400, 8'd0, 1'b1, 1'b0};
      6'h05: e = '{16'h0502, 8'd24, 1'b1, 1'b0};
      6'h06: e = '{16'h0606, 8'd0, 1'b0, 1'b0};
      6'h07: e = '{16'h0700, 8'd0, 1'b1, 1'b0};
      6'h08: e = '{16'h0800, 8'd0, 1'b1, 1'b0};
      6'h09: e = '{16'h0900, 8'd0, 1'b1, 1'b0};
      6'h0a: e = '{16'h0a00, 8'd0, 1'b1, 1'b0};
      6'h0b: e = '{16'h0b00, 8'd0, 1'b1, 1'b0};
      6'h0c: e = '{16'h0c00, 8'd0, 1'b1, 1'b0};
      6'h0d: e = '{16'h0d02, 8'd2, 1'b1, 1'b0};
      6'h0e: e = '{16'h0e02, 8'd2, 1'b1, 1'b0};
      6'h0f: e = '{16'h0f03, 8'd4, 1'b1, 1'b0};
      6'h10: e = '{16'h1003, 8'd0, 1'b0, 1'b0};
      6'h11: e = '{16'h1100, 8'd0, 1'b1, 1'b0};
      6'h12: e = '{16'h1206, 8'd0, 1'b0, 1'b0};
      6'h13: e = '{16'h1302, 8'd4, 1'b1, 1'b0};
      6'h14: e = '{16'h1400, 8'd0, 1'b1, 1'b0};
      6'h15: e = '{16'h1500, 8'd0, 1'b1, 1'b0};
      6'h16: e = '{16'h1602, 8'd2, 1'b1, 1'b0};
      6'h17: e = '{16'h1701, 8'd2, 1'b1, 1'b0};
      6'h19: e = '{16'h1906, 8'd0, 1'b0, 1'b0};
      6'h1a: e = '{16'h1a01, 8'd2, 1'b1, 1'b0};
      6'h1b: e = '{16'h1b05, 8'd8, 1'b1, 1'b0};
      6'h1c: e = '{16'h1c05, 8'd8, 1'b1, 1'b0};
      6'h1f: e = '{16'h1f06, 8'd0, 1'b0, 1'b0};
      6'h20: e = '{16'h2006, 8'd176, 1'b1, 1'b0};
      6'h21: e = '{16'h2102, 8'd2, 1'b1, 1'b0};
      6'h22: e = '{16'h2202, 8'd2, 1'b1, 1'b0};
      6'h23: e = '{16'h2306, 8'd0, 1'b0, 1'b0};
      6'h24: e = '{16'h2406, 8'd0, 1'b0, 1'b1};
      6'h25: e = '{16'h2502, 8'd2, 1'b1, 1'b1};
      6'h26: e = '{16'h2601, 8'd2, 1'b1, 1'b0};
      6'h27: e = '{16'h2703, 8'd4, 1'b1, 1'b0};
      6'h28: e = '{16'h0000, 8'd2, 1'b1, 1'b0};
      6'h29: e = '{16'h0000, 8'd4, 1'b1, 1'b0};
      6'h2a: e = '{16'h2a02, 8'd2, 1'b1, 1'b0};
      6'h2b: e = '{16'h2b02, 8'd2, 1'b1, 1'b0};
      6'h2c: e = '{16'h2c06, 8'd0, 1'b0, 1'b0};
      6'h2d: e = '{16'h2d00, 8'd0, 1'b1, 1'b0};
      6'h2e: e = '{16'h2e02, 8'd2, 1'b1, 1'b0};
      6'h2f: e = '{16'h2f03, 8'd4, 1'b1, 1'b0};
      6'h30: e = '{16'h3003, 8'd4, 1'b1, 1'b0};
      6'h31: e = '{16'h3103, 8'd4, 1'b1, 1'b0};
      6'h32: e = '{16'h3202, 8'd2, 1'b1, 1'b1};
      6'h33: e = '{16'h3302, 8'd2, 1'b1, 1'b1};
      6'h34: e = '{16'h3401, 8'd2, 1'b1, 1'b1};
      6'h35: e = '{16'h3503, 8'd4, 1'b1, 1'b1};
      6'h36: e = '{16'h3602, 8'd2, 1'b1, 1'b0};
      6'h37: e = '{16'h3706, 8'd0, 1'b0, 1'b0};
      6'h38: e = '{16'h3800, 8'd0, 1'b1, 1'b0};
      default: e = '{16'h0000, 8'd0, 1'b0, 1'b0};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

@@ design/gdsii_record_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// gdsii_record_stream_parser_unit: GDSII record stream parser
// Splits a byte stream into records and data elements, with cell selection.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one stream byte per item in tdata[7:0].
//   m_axis: one result per item; tdata holds record_index, data_kind,
//   element_value, element_number; tuser holds the five flags.
//   cfg: index 0..3 write the cell name characters, index 4 its length.
// Each byte is parsed in the cycle it is accepted; its result, if any, sits
// in the output register from the next cycle. One byte per cycle
// is taken while the output register is empty or being drained in the same
// cycle; a stalled receiver holds the result and backs up s_axis_tready.
// Bytes that give no result leave the output untouched.
// Reset returns to the length high byte, clears halt, shows all cells.
// After an illegal code or end of stream, later bytes are taken and dropped.
`default_nettype none
module gdsii_record_stream_parser_unit
  import grsp_pkg::*;
#(
  parameter int unsigned NAME_CHARS = grsp_pkg::NameCharsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] stream_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [5:0] record_index, [8:6] data_kind, [72:9] element_value,
  // [88:73] element_number, [95:89] zero
  output logic [95:0]       m_axis_tdata,
  // [0] is_header, [1] is_last, [2] length_mismatch, [3] illegal_code,
  // [4] end_of_stream
  output logic [4:0]        m_axis_tuser,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i
);

  localparam int unsigned PosW = $clog2(NAME_CHARS + 1);

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] code_q, code_d;
  logic [15:0] cnt_q, cnt_d;
  logic [63:0] shift_q, shift_d;
  logic        sel_q, sel_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic        matching_q, matching_d;
  logic        ended_q, ended_d;
  logic        halted_q, halted_d;
  logic [7:0]  name_q [NAME_CHARS];
  logic [5:0]  nlen_q;
  logic [PosW-1:0] nlen_eff;
  result_t     res_q, res_d;
  logic        ovalid_q, emit;

  logic        in_fire;
  logic [7:0]  b;

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign b = s_axis_tdata;

  always_comb begin
    if (nlen_q > 6'(NAME_CHARS)) nlen_eff = PosW'(NAME_CHARS);
    else nlen_eff = PosW'(nlen_q);
  end

  // name characters stored per byte; only NAME_CHARS of them are kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAME_CHARS; i++) begin
        name_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NAME_CHARS; i++) begin
        if (cfg_valid_i && cfg_index_i == 3'(i / 8)) begin
          name_q[i] <= cfg_data_i[(i % 8) * 8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nlen_q <= '0;
    end else if (cfg_valid_i && cfg_index_i == CfgNameLen) begin
      nlen_q <= cfg_data_i[5:0];
    end
  end

  // parse one byte
  always_comb begin
    rec_entry_t  e;
    logic [5:0]  ndx;
    logic [7:0]  kind8;
    logic [2:0]  kind;
    logic [15:0] plen, code_n, len_n, off;
    logic        mism, data, shown, last, sel_b, cmp_ok;
    logic [2:0]  esz_m;
    logic [15:0] num;
    logic [63:0] v;
    logic [PosW-1:0] pos_idx;

    phase_d = phase_q; len_d = len_q; code_d = code_q; cnt_d = cnt_q;
    shift_d = shift_q; sel_d = sel_q; pos_d = pos_q; matching_d = matching_q;
    ended_d = ended_q; halted_d = halted_q;
    res_d = '0; emit = 1'b0;
    e = '0; ndx = '0; kind8 = '0; kind = '0; plen = '0; code_n = '0; len_n = '0;
    off = '0; mism = 1'b0; data = 1'b0; shown = 1'b0; last = 1'b0; sel_b = 1'b0;
    cmp_ok = 1'b0; esz_m = '0; num = '0; v = '0; pos_idx = '0;

    if (in_fire && !halted_q) begin
      unique case (phase_q)
        PH_LEN_HI: begin
          len_d = {b, 8'h00};
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_n = {len_q[15:8], b};
          len_d = len_n;
          if (len_n[15]) begin
            halted_d = 1'b1;
            emit = 1'b1;
            res_d.end_of_stream = 1'b1;
          end else begin
            phase_d = (len_n != 16'd0) ? PH_CODE_HI : PH_LEN_HI;
          end
        end
        PH_CODE_HI: begin
          code_d = {b, 8'h00};
          phase_d = PH_CODE_LO;
        end
        PH_CODE_LO: begin
          code_n = {code_q[15:8], b};
          code_d = code_n;
          plen = (len_q >= 16'd4) ? len_q - 16'd4 : 16'd0;
          cnt_d = '0; shift_d = '0; pos_d = '0; matching_d = 1'b1; ended_d = 1'b0;
          phase_d = (plen != 16'd0) ? PH_PAYLOAD : PH_LEN_HI;
          if (code_n[15:8] <= {2'b00, LastIndex}) begin
            ndx = code_n[13:8];
            e = rec_lookup(ndx);
            if (e.code != code_n) begin
              halted_d = 1'b1;
              emit = 1'b1;
              res_d.record_index = ndx;
              res_d.element_value = {48'd0, code_n};
              res_d.is_header = 1'b1;
              res_d.is_last = 1'b1;
              res_d.illegal_code = 1'b1;
            end else begin
              sel_b = sel_q;
              if (code_n[15:8] == BgnstrIndex || code_n[15:8] == EndstrIndex) begin
                sel_b = (nlen_eff == '0);
              end
              if (code_n[15:8] == StrnameIndex && plen == 16'd0) begin
                sel_b = (nlen_eff == '0) || (nlen_eff == '0);
              end
              sel_d = sel_b;
              if (sel_b || code_n[15:8] == StrnameIndex) begin
                mism = (len_q < 16'd4) || (e.fixed && plen != {8'd0, e.len})
                  || (code_n == XyCode && plen[2:0] != 3'd0);
                data = (code_n[7:0] != 8'd0) && !e.hidden;
                emit = 1'b1;
                res_d.record_index = ndx;
                res_d.data_kind = code_n[2:0];
                res_d.element_value = {48'd0, plen};
                res_d.is_header = 1'b1;
                res_d.is_last = (plen == 16'd0) || !data;
                res_d.length_mismatch = mism;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          off = cnt_q;
          cnt_d = cnt_q + 16'd1;
          plen = (len_q >= 16'd4) ? len_q - 16'd4 : 16'd0;
          last = cnt_d >= plen;
          if (last) phase_d = PH_LEN_HI;
          shift_d = {shift_q[55:0], b};
          kind8 = code_q[7:0];
          kind = code_q[2:0];
          if (code_q[15:8] <= {2'b00, LastIndex}) begin
            ndx = code_q[13:8];
            e = rec_lookup(ndx);
            shown = (sel_q || code_q[15:8] == StrnameIndex) && kind8 != 8'd0 && !e.hidden;
            if (code_q[15:8] == StrnameIndex) begin
              pos_idx = pos_q;
              cmp_ok = 1'b0;
              for (int i = 0; i < NAME_CHARS; i++) begin
                if (pos_idx == PosW'(i) && b == name_q[i]) cmp_ok = 1'b1;
              end
              if (!ended_q) begin
                if (b == 8'd0) ended_d = 1'b1;
                else if (matching_q && pos_q < nlen_eff && cmp_ok) pos_d = pos_q + 1'b1;
                else matching_d = 1'b0;
              end
              if (last) sel_d = (nlen_eff == '0) || (matching_d && pos_d == nlen_eff);
            end
            // element size mask and element number
            unique case (kind)
              KindBits, KindInt2: begin esz_m = 3'd1; num = {1'b0, off[15:1]}; end
              KindInt4: begin esz_m = 3'd3; num = {2'b0, off[15:2]}; end
              KindReal8: begin esz_m = 3'd7; num = {3'b0, off[15:3]}; end
              default: begin esz_m = 3'd0; num = off; end
            endcase
            if (shown) begin
              if (((off[2:0] & esz_m) == esz_m) && !(kind == KindAscii && b == 8'd0)) begin
                case (kind)
                  KindInt2: v = {{48{shift_d[15]}}, shift_d[15:0]};
                  KindInt4: v = {{32{shift_d[31]}}, shift_d[31:0]};
                  KindBits: v = {48'd0, shift_d[15:0]};
                  KindReal8: v = shift_d;
                  default: begin
                    v = {56'd0, b};
                    if (code_q[15:8] == StringIndex && b >= 8'h09 && b <= 8'h0d) v = 64'h20;
                  end
                endcase
                emit = 1'b1;
                res_d.record_index = ndx;
                res_d.data_kind = kind;
                res_d.element_value = v;
                res_d.element_number = num;
                res_d.is_last = last;
              end else if (last) begin
                emit = 1'b1;
                res_d.record_index = ndx;
                res_d.element_number = num;
                res_d.is_last = 1'b1;
              end
            end
          end
        end
        default: phase_d = PH_LEN_HI;
      endcase
    end

    // length write resets the selection (write it only while idle; the block does not enforce this)
    if (cfg_valid_i && cfg_index_i == CfgNameLen) begin
      sel_d = (cfg_data_i[5:0] == 6'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN_HI;
      len_q <= '0; code_q <= '0; cnt_q <= '0; shift_q <= '0;
      sel_q <= 1'b1; pos_q <= '0; matching_q <= 1'b1; ended_q <= 1'b0;
      halted_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      phase_q <= phase_d; len_q <= len_d; code_q <= code_d; cnt_q <= cnt_d;
      shift_q <= shift_d; sel_q <= sel_d; pos_q <= pos_d;
      matching_q <= matching_d; ended_q <= ended_d; halted_q <= halted_d;
      if (emit) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= res_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {7'd0, res_q.element_number, res_q.element_value,
                         res_q.data_kind, res_q.record_index};
  assign m_axis_tuser = {res_q.end_of_stream, res_q.illegal_code, res_q.length_mismatch,
                         res_q.is_last, res_q.is_header};

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the GDSII record stream parser
// Feeds record streams byte by byte with random bursts and output stalls,
// predicts every result from a local model of the parser and compares them.
// ----------------------------------------------------------------------------
module tb_top;
  import grsp_pkg::*;

  localparam int          MaxCycles = 300000;
  localparam logic [31:0] CfgSpare  = 32'd5;

  // {code, payload length, flags}; flags bit 0 fixed length, bit 1 no data display
  localparam logic [31:0] RecTab [57] = '{
    32'h0002_02_01, 32'h0102_18_01, 32'h0206_00_00, 32'h0305_10_01,
    32'h0400_00_01, 32'h0502_18_01, 32'h0606_00_00, 32'h0700_00_01,
    32'h0800_00_01, 32'h0900_00_01, 32'h0a00_00_01, 32'h0b00_00_01,
    32'h0c00_00_01, 32'h0d02_02_01, 32'h0e02_02_01, 32'h0f03_04_01,
    32'h1003_00_00, 32'h1100_00_01, 32'h1206_00_00, 32'h1302_04_01,
    32'h1400_00_01, 32'h1500_00_01, 32'h1602_02_01, 32'h1701_02_01,
    32'h0000_00_00, 32'h1906_00_00, 32'h1a01_02_01, 32'h1b05_08_01,
    32'h1c05_08_01, 32'h0000_00_00, 32'h0000_00_00, 32'h1f06_00_00,
    32'h2006_b0_01, 32'h2102_02_01, 32'h2202_02_01, 32'h2306_00_00,
    32'h2406_00_02, 32'h2502_02_03, 32'h2601_02_01, 32'h2703_04_01,
    32'h0000_02_01, 32'h0000_04_01, 32'h2a02_02_01, 32'h2b02_02_01,
    32'h2c06_00_00, 32'h2d00_00_01, 32'h2e02_02_01, 32'h2f03_04_01,
    32'h3003_04_01, 32'h3103_04_01, 32'h3202_02_03, 32'h3302_02_03,
    32'h3401_02_03, 32'h3503_04_03, 32'h3602_02_01, 32'h3706_00_00,
    32'h3800_00_01
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  gdsii_record_stream_parser_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [7:0] byte_q[$];
  result_t    result_q[$];
  int         errors = 0;
  int         cycles = 0;

  // parser model state
  logic [63:0] name_reg [4];
  logic [5:0]  name_len_reg;
  phase_e      phase;
  logic [15:0] rec_len, rec_code, pay_cnt;
  logic [63:0] shift_reg;
  logic        selected, name_ok, name_done, halted;
  logic [5:0]  name_pos;

  function automatic logic [5:0] eff_name_len();
    return (name_len_reg > 6'd32) ? 6'd32 : name_len_reg;
  endfunction

  function automatic logic [7:0] name_char(logic [5:0] i);
    return name_reg[i[4:3]][i[2:0]*8 +: 8];
  endfunction

  function automatic logic [15:0] pay_len();
    return (rec_len >= 16'd4) ? rec_len - 16'd4 : 16'd0;
  endfunction

  function automatic void close_name();
    selected = (eff_name_len() == 0) || (name_ok && name_pos == eff_name_len());
  endfunction

  function automatic void push_result(logic [7:0] ndx, logic [2:0] kind, logic [63:0] val,
                                      logic [15:0] num, logic hdr, logic last, logic mism,
                                      logic ill, logic eos);
    result_t r;
    r.record_index    = ndx[5:0];
    r.data_kind       = kind;
    r.element_value   = val;
    r.element_number  = num;
    r.is_header       = hdr;
    r.is_last         = last;
    r.length_mismatch = mism;
    r.illegal_code    = ill;
    r.end_of_stream   = eos;
    result_q.push_back(r);
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < 4; i++) name_reg[i] = '0;
    name_len_reg = '0;
    phase = PH_LEN_HI;
    rec_len = '0;
    rec_code = '0;
    pay_cnt = '0;
    shift_reg = '0;
    selected = 1'b1;
    name_pos = '0;
    name_ok = 1'b1;
    name_done = 1'b0;
    halted = 1'b0;
  endfunction

  function automatic void write_model_reg(logic [2:0] idx, logic [63:0] val);
    if (idx <= CfgName3) begin
      name_reg[idx[1:0]] = val;
    end else if (idx == CfgNameLen) begin
      name_len_reg = val[5:0];
      selected = (val[5:0] == 0);
    end
  endfunction

  function automatic void open_record();
    logic [7:0]  ndx;
    logic [15:0] plen;
    logic [2:0]  kind;
    logic [31:0] e;
    logic        mism, data;
    ndx = rec_code[15:8];
    plen = pay_len();
    kind = rec_code[2:0];
    pay_cnt = '0;
    shift_reg = '0;
    name_pos = '0;
    name_ok = 1'b1;
    name_done = 1'b0;
    phase = (plen != 0) ? PH_PAYLOAD : PH_LEN_HI;
    if (ndx > LastIndex) return;
    e = RecTab[ndx];
    if (e[31:16] != rec_code) begin
      halted = 1'b1;
      push_result(ndx, 3'd0, {48'd0, rec_code}, 16'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
      return;
    end
    if (ndx == BgnstrIndex || ndx == EndstrIndex) selected = (eff_name_len() == 0);
    if (ndx == StrnameIndex && plen == 0) close_name();
    if (!selected && ndx != StrnameIndex) return;
    mism = (rec_len < 16'd4) || (e[0] && plen != {8'd0, e[15:8]})
        || (rec_code == XyCode && plen[2:0] != 0);
    data = (rec_code[7:0] != 0) && !e[1];
    push_result(ndx, kind, {48'd0, plen}, 16'd0, 1'b1, (plen == 0) || !data, mism,
                1'b0, 1'b0);
  endfunction

  function automatic void payload_byte(logic [7:0] b);
    logic [7:0]  ndx;
    logic [2:0]  kind;
    logic [15:0] off, esz;
    logic        last, shown;
    logic [63:0] v;
    ndx = rec_code[15:8];
    kind = rec_code[2:0];
    off = pay_cnt;
    case (kind)
      KindBits, KindInt2: esz = 16'd2;
      KindInt4:           esz = 16'd4;
      KindReal8:          esz = 16'd8;
      default:            esz = 16'd1;
    endcase
    pay_cnt = pay_cnt + 16'd1;
    last = pay_cnt >= pay_len();
    if (last) phase = PH_LEN_HI;
    shift_reg = {shift_reg[55:0], b};
    if (ndx > LastIndex) return;
    shown = (selected || ndx == StrnameIndex) && rec_code[7:0] != 0 && !RecTab[ndx][1];
    if (ndx == StrnameIndex) begin
      if (!name_done) begin
        if (b == 0) name_done = 1'b1;
        else if (name_ok && name_pos < eff_name_len() && b == name_char(name_pos))
          name_pos = name_pos + 6'd1;
        else name_ok = 1'b0;
      end
      if (last) close_name();
    end
    if (!shown) return;
    if (((off + 16'd1) % esz) == 0 && !(rec_code[7:0] == KindAscii && b == 0)) begin
      case (rec_code[7:0])
        KindInt2:  v = {{48{shift_reg[15]}}, shift_reg[15:0]};
        KindInt4:  v = {{32{shift_reg[31]}}, shift_reg[31:0]};
        KindBits:  v = {48'd0, shift_reg[15:0]};
        KindReal8: v = shift_reg;
        default: begin
          v = {56'd0, b};
          if (ndx == StringIndex && b >= 8'h09 && b <= 8'h0d) v = 64'h20;
        end
      endcase
      push_result(ndx, kind, v, off / esz, 1'b0, last, 1'b0, 1'b0, 1'b0);
    end else if (last) begin
      push_result(ndx, 3'd0, 64'd0, off / esz, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    if (halted) return;
    case (phase)
      PH_LEN_LO: begin
        rec_len[7:0] = b;
        if (rec_len[15]) begin
          halted = 1'b1;
          push_result(8'd0, 3'd0, 64'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        end else begin
          phase = (rec_len != 0) ? PH_CODE_HI : PH_LEN_HI;
        end
      end
      PH_CODE_HI: begin
        rec_code = {b, 8'd0};
        phase = PH_CODE_LO;
      end
      PH_CODE_LO: begin
        rec_code[7:0] = b;
        open_record();
      end
      PH_PAYLOAD: payload_byte(b);
      default: begin
        rec_len = {b, 8'd0};
        phase = PH_LEN_LO;
      end
    endcase
  endfunction

  // sender: bursts of items with random gaps
  int burst_left = 8;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the item until taken
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= byte_q.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes with bits 11:10 of the cycle counter
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (cycles[11:10])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= ($urandom_range(3) != 0);
        2'd2:    m_axis_tready <= (cycles[3:0] < 4'd5);
        default: m_axis_tready <= ($urandom_range(1) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    result_t want, got;
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("tb_top NOT OK");
      $finish;
    end else if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.record_index    = m_axis_tdata[5:0];
      got.data_kind       = m_axis_tdata[8:6];
      got.element_value   = m_axis_tdata[72:9];
      got.element_number  = m_axis_tdata[88:73];
      got.is_header       = m_axis_tuser[0];
      got.is_last         = m_axis_tuser[1];
      got.length_mismatch = m_axis_tuser[2];
      got.illegal_code    = m_axis_tuser[3];
      got.end_of_stream   = m_axis_tuser[4];
      if (result_q.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.record_index != want.record_index) begin
          $error("record_index exp %0h got %0h", want.record_index, got.record_index);
          errors++;
        end
        if (got.data_kind != want.data_kind) begin
          $error("data_kind exp %0d got %0d", want.data_kind, got.data_kind);
          errors++;
        end
        if (got.element_value != want.element_value) begin
          $error("element_value exp %0h got %0h", want.element_value, got.element_value);
          errors++;
        end
        if (got.element_number != want.element_number) begin
          $error("element_number exp %0d got %0d", want.element_number, got.element_number);
          errors++;
        end
        if (got.is_header != want.is_header) begin
          $error("is_header exp %0b got %0b", want.is_header, got.is_header);
          errors++;
        end
        if (got.is_last != want.is_last) begin
          $error("is_last exp %0b got %0b", want.is_last, got.is_last);
          errors++;
        end
        if (got.length_mismatch != want.length_mismatch) begin
          $error("length_mismatch exp %0b got %0b", want.length_mismatch,
                 got.length_mismatch);
          errors++;
        end
        if (got.illegal_code != want.illegal_code) begin
          $error("illegal_code exp %0b got %0b", want.illegal_code, got.illegal_code);
          errors++;
        end
        if (got.end_of_stream != want.end_of_stream) begin
          $error("end_of_stream exp %0b got %0b", want.end_of_stream, got.end_of_stream);
          errors++;
        end
      end
    end
  end

  // ---- stimulus helpers ----
  task automatic put_header(int len_word, logic [15:0] code);
    byte_q.push_back(len_word[15:8]);
    byte_q.push_back(len_word[7:0]);
    if (len_word != 0) begin
      byte_q.push_back(code[15:8]);
      byte_q.push_back(code[7:0]);
    end
  endtask

  function automatic logic [7:0] ascii_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'($urandom_range(9, 13));
      2:       return 8'($urandom);
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  task automatic put_payload(logic [15:0] code, int plen);
    for (int i = 0; i < plen; i++)
      byte_q.push_back((code[7:0] == KindAscii) ? ascii_byte() : 8'($urandom));
  endtask

  task automatic legal_record(int ndx);
    logic [15:0] code;
    int plen;
    code = RecTab[ndx][31:16];
    if (RecTab[ndx][0] && $urandom_range(4) != 0) plen = RecTab[ndx][15:8];
    else if (code == XyCode && $urandom_range(3) != 0) plen = 8 * $urandom_range(0, 4);
    else plen = $urandom_range(0, 12);
    put_header(plen + 4, code);
    put_payload(code, plen);
  endtask

  function automatic int legal_index();
    int n;
    do n = $urandom_range(56); while (RecTab[n][31:16] == 0);
    return n;
  endfunction

  task automatic cell_struct();
    int n, extra;
    legal_record(BgnstrIndex);
    n = eff_name_len();
    extra = $urandom_range(3);
    case ($urandom_range(3))
      0, 1: begin
        // configured name, optionally padded
        put_header(n + extra + 4, 16'h0606);
        for (int i = 0; i < n; i++) byte_q.push_back(name_char(6'(i)));
        for (int i = 0; i < extra; i++) byte_q.push_back((i == 0) ? 8'h00 : ascii_byte());
      end
      2: begin
        // name with one character off
        put_header(n + 4, 16'h0606);
        for (int i = 0; i < n; i++)
          byte_q.push_back((i == n - 1) ? name_char(6'(i)) ^ 8'h01 : name_char(6'(i)));
      end
      default: legal_record(StrnameIndex);
    endcase
    repeat ($urandom_range(1, 5)) legal_record(legal_index());
    put_header(4, 16'h0700);
  endtask

  task automatic random_stream(int nbytes);
    int target;
    int len;
    target = byte_q.size() + nbytes;
    while (byte_q.size() < target) begin
      case ($urandom_range(19))
        0:       put_header(0, 16'h0);
        1:       put_header($urandom_range(1, 3), RecTab[legal_index()][31:16]);
        2: begin
          len = $urandom_range(4, 12);
          put_header(len, {8'($urandom_range(57, 255)), 8'($urandom)});
          put_payload(16'h0, len - 4);
        end
        3, 4, 5: cell_struct();
        default: legal_record(legal_index());
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (byte_q.size() != 0 || s_axis_tvalid || result_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    write_model_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_name(int len, bit ones);
    logic [63:0] w;
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 8; k++) w[k*8 +: 8] = ones ? 8'hff : 8'($urandom_range(33, 126));
      write_reg(3'(r), w);
    end
    write_reg(CfgNameLen, 64'(len));
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed records
    put_header(6, 16'h0002);  byte_q.push_back(8'h80); byte_q.push_back(8'h00);
    put_header(6, 16'h0d02);  byte_q.push_back(8'h7f); byte_q.push_back(8'hff);
    put_header(0, 16'h0);
    put_header(2, 16'h0d02);
    put_header(8, 16'h1906);
    byte_q.push_back(8'h41); byte_q.push_back(8'h09); byte_q.push_back(8'h00);
    byte_q.push_back(8'hff);
    put_header(7, 16'h1003);  put_payload(16'h1003, 3);
    put_header(6, 16'h3900);  put_payload(16'h0, 2);
    wait_drained();

    write_reg(CfgSpare[2:0], 64'($urandom));
    random_stream(240);
    wait_drained();
    set_name($urandom_range(1, 8), 0);
    random_stream(240);
    wait_drained();
    set_name(32, 0);
    random_stream(240);
    wait_drained();
    set_name(63, 1);
    random_stream(240);
    wait_drained();
    write_reg(CfgNameLen, 64'd0);
    random_stream(100);

    // terminate the stream, then show that later bytes are dropped
    if ($urandom_range(1) == 0) put_header(6, 16'h1800);
    else begin
      byte_q.push_back(8'($urandom_range(128, 255)));
      byte_q.push_back(8'($urandom));
    end
    put_payload(16'h0, 12);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ gdsii_record_stream_parser_unit.f @@
design/grsp_pkg.sv
design/gdsii_record_stream_parser_unit.sv
tb/tb_top.sv
